/* hw/rtl/mtee_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI track event encoder package
// Shared types and constants for the track byte stream encoder.
// ----------------------------------------------------------------------------
package mtee_pkg;

	// Variable-length quantity layout: 7-bit groups, five of them for 32 bits.
	localparam int unsigned GroupW    = 7;
	localparam int unsigned NumGroups = 5;
	localparam int unsigned TickW     = 32;
	localparam int unsigned VlqW      = GroupW * NumGroups;
	localparam int unsigned NumSlots  = 8;
	localparam int unsigned CountW    = 32;

	localparam logic [7:0] ContBit   = 8'h80;
	localparam logic [7:0] MetaMark  = 8'hff;
	localparam logic [7:0] MetaEot   = 8'h2f;
	localparam logic [7:0] ZeroByte  = 8'h00;

	// Only the low four bits of the top group come from a 32-bit delta.
	localparam logic [GroupW-1:0] TopGroupMask = 7'h0f;

	typedef enum logic {
		ACT_EVENT = 1'b0,
		ACT_EOT   = 1'b1
	} action_t;

	typedef struct packed {
		logic             action;
		logic [TickW-1:0] tick;
		logic [7:0]       status;
		logic [7:0]       data_one;
		logic [7:0]       data_two;
	} src_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic              last;
		logic [CountW-1:0] track_bytes;
	} dst_t;

	// Byte slots handed to the emitter; slot NumSlots-1 goes out first.
	typedef struct packed {
		logic                           valid;
		logic                           eot;
		logic [NumSlots-1:0][7:0]       bytes;
		logic [NumSlots-1:0]            keep;
	} load_t;

	typedef enum logic {
		ST_IDLE,
		ST_DELTA
	} state_t;

endpackage

/* hw/rtl/mtee_delta.sv */
// ----------------------------------------------------------------------------
// Digit-serial delta unit
// Subtracts the previous tick from the new tick one 7-bit group per cycle,
// least significant group first, and collects the groups of the result.
// ----------------------------------------------------------------------------
module mtee_delta (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	input  logic [mtee_pkg::TickW-1:0]                     tick,
	input  logic [mtee_pkg::TickW-1:0]                     prev,
	output logic                                           done,
	output logic [mtee_pkg::NumGroups-1:0][mtee_pkg::GroupW-1:0] groups,
	output logic [mtee_pkg::NumGroups-1:0]                 nonzero
);
	import mtee_pkg::*;

	localparam int unsigned CntW = $clog2(NumGroups);
	localparam logic [CntW-1:0] LastCnt = CntW'(NumGroups - 1);

	logic [VlqW-1:0]         a_q;
	logic [VlqW-1:0]         b_q;
	logic                    borrow_q;
	logic [VlqW-1:0]         grp_q;
	logic [NumGroups-1:0]    nz_q;
	logic [CntW-1:0]         cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [GroupW:0]         diff;
	logic [GroupW-1:0]       digit;

	// One group of the subtraction with the borrow from the group below.
	always_comb begin
		diff  = {1'b0, a_q[GroupW-1:0]} - {1'b0, b_q[GroupW-1:0]} - {{GroupW{1'b0}}, borrow_q};
		digit = (cnt_q == LastCnt) ? (diff[GroupW-1:0] & TopGroupMask) : diff[GroupW-1:0];
	end

	// Control: counter of groups and the done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastCnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and result shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q      <= {{(VlqW-TickW){1'b0}}, tick};
			b_q      <= {{(VlqW-TickW){1'b0}}, prev};
			borrow_q <= 1'b0;
		end else if (busy_q) begin
			a_q      <= a_q >> GroupW;
			b_q      <= b_q >> GroupW;
			borrow_q <= diff[GroupW];
			grp_q    <= {digit, grp_q[VlqW-1:GroupW]};
			nz_q     <= {|digit, nz_q[NumGroups-1:1]};
		end
	end

	assign done    = done_q;
	assign groups  = grp_q;
	assign nonzero = nz_q;

endmodule

/* hw/rtl/mtee_emit.sv */
// ----------------------------------------------------------------------------
// Byte emitter
// Shifts byte slots out one per cycle while a kept byte finds the output
// register free, skipping unkept slots; kept bytes carry the running count.
// ----------------------------------------------------------------------------
module mtee_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  mtee_pkg::load_t  load,
	output logic             busy,
	output logic             dst_valid,
	input  logic             dst_ready,
	output mtee_pkg::dst_t   dst_data
);
	import mtee_pkg::*;

	logic [NumSlots-1:0][7:0] sh_q;
	logic [NumSlots-1:0]      keep_q;
	logic                     eot_q;
	logic [CountW-1:0]        cnt_q;
	logic                     out_valid_q;
	dst_t                     out_q;
	logic                     head_keep;
	logic                     head_last;
	logic                     advance;
	logic                     take;

	always_comb begin
		head_keep = keep_q[NumSlots-1];
		head_last = (keep_q[NumSlots-2:0] == '0);
		take      = out_valid_q && dst_ready;
		// A skipped slot always moves; a kept one needs a free output register.
		advance   = (keep_q != '0) && (!head_keep || !out_valid_q || dst_ready);
	end

	// Slot shift register and running count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= '0;
			eot_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (keep_q == '0) begin
				if (load.valid) begin
					keep_q <= load.keep;
					eot_q  <= load.eot;
				end
			end else if (advance) begin
				keep_q <= keep_q << 1;
				if (head_keep) begin
					cnt_q <= (head_last && eot_q) ? '0 : cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keep_q == '0) begin
			if (load.valid) begin
				sh_q <= load.bytes;
			end
		end else if (advance) begin
			sh_q <= sh_q << 8;
		end
	end

	// Output register: holds a byte until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && head_keep) begin
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_keep) begin
			out_q.out_byte    <= sh_q[NumSlots-1];
			out_q.last        <= head_last;
			out_q.track_bytes <= cnt_q + 1'b1;
		end
	end

	assign busy      = (keep_q != '0);
	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

endmodule

/* hw/rtl/midi_track_event_encoder_unit.sv */
// ----------------------------------------------------------------------------
// MIDI track event encoder
// Turns time-sorted channel events into a track byte stream: delta time as a
// variable-length quantity, then status and two data bytes; end of track
// emits the end-of-track meta event and clears the tick and byte count.
//
//   channel | direction | handshake              | payload
//   src     | in        | src_valid / src_ready  | src_data (action, tick, bytes)
//   dst     | out       | dst_valid / dst_ready  | dst_data (byte, last, count)
//
// A channel event is accepted, goes through the digit-serial subtractor (one
// 7-bit group per cycle), is loaded into the emitter, then passes the eight
// emitter slots, one byte or skipped slot at a time; no new request is
// taken until the emitter is empty.
// An end-of-track request loads the emitter as it is accepted.
// Each stalled cycle on dst holds the emitter on a kept byte.
// Reset clears the previous tick, the byte count and all control state.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_valid,
	output logic            src_ready,
	input  mtee_pkg::src_t  src_data,
	output logic            dst_valid,
	input  logic            dst_ready,
	output mtee_pkg::dst_t  dst_data
);
	import mtee_pkg::*;

	state_t                             state_q;
	state_t                             state_d;
	logic [TickW-1:0]                   prev_q;
	logic [7:0]                         status_q;
	logic [7:0]                         data_one_q;
	logic [7:0]                         data_two_q;
	logic                               accept;
	logic                               delta_start;
	logic                               delta_done;
	logic [NumGroups-1:0][GroupW-1:0]   groups;
	logic [NumGroups-1:0]               nonzero;
	logic                               emit_busy;
	load_t                              load;

	assign accept = src_valid && src_ready;

	mtee_delta u_delta (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (delta_start),
		.tick    (src_data.tick),
		.prev    (prev_q),
		.done    (delta_done),
		.groups  (groups),
		.nonzero (nonzero)
	);

	mtee_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.busy      (emit_busy),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, request handshake and emitter load.
	always_comb begin
		state_d     = state_q;
		src_ready   = 1'b0;
		delta_start = 1'b0;
		load        = '0;
		case (state_q)
			ST_IDLE: begin
				src_ready = !emit_busy;
				if (accept) begin
					if (src_data.action == ACT_EOT) begin
						load.valid = 1'b1;
						load.eot   = 1'b1;
						load.bytes = {{(NumSlots-4){ZeroByte}}, ZeroByte, MetaMark, MetaEot,
							ZeroByte};
						load.keep  = {{(NumSlots-4){1'b0}}, 4'b1111};
					end else begin
						delta_start = 1'b1;
						state_d     = ST_DELTA;
					end
				end
			end
			ST_DELTA: begin
				if (delta_done) begin
					load.valid = 1'b1;
					for (int i = 0; i < NumGroups; i++) begin
						// Group i sits in slot i+3; every group above zero carries
						// the continuation bit.
						load.bytes[i+3] = {(i != 0), groups[i]};
						load.keep[i+3]  = (i == 0) || (|(nonzero >> i));
					end
					load.bytes[2] = status_q;
					load.bytes[1] = data_one_q;
					load.bytes[0] = data_two_q;
					load.keep[2:0] = 3'b111;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Previous tick: follows each event, cleared by end of track.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= (src_data.action == ACT_EOT) ? '0 : src_data.tick;
		end
	end

	// Event bytes held while the delta is worked out.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= src_data.status;
			data_one_q <= src_data.data_one;
			data_two_q <= src_data.data_two;
		end
	end

`ifndef SYNTHESIS
	// The subtractor finishes only while the control waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		delta_done |-> state_q == ST_DELTA)
		else $error("delta result outside of the delta state");

	// No new request is taken while a delta is being worked out.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DELTA |-> !src_ready)
		else $error("request accepted during delta");

	// An accepted channel event moves the control to the delta state.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_data.action == ACT_EVENT |=> state_q == ST_DELTA)
		else $error("channel event did not start the delta");

	// The emitter is never loaded while it still holds slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		load.valid |-> !emit_busy)
		else $error("emitter loaded while busy");
`endif

endmodule

/* sim/tb_midi_track_event_encoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the MIDI track event encoder
// Channel events and end-of-track requests are fed through the src handshake.
// Each accepted request is encoded by a local predictor into the expected
// track bytes. Every byte taken from dst is checked against the oldest
// expected byte. Both sides idle in random bursts, and one long output stall
// backs the encoder up against its input.
// ----------------------------------------------------------------------------
module tb_midi_track_event_encoder_unit;

	import mtee_pkg::*;

	localparam int unsigned HoldCycles  = 400;
	localparam int unsigned HoldAfter   = 30;
	localparam int unsigned QuietTail   = 20;
	localparam int unsigned DrainCycles = 40;
	localparam int unsigned RandomItems = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	src_t src_data = '0;
	logic dst_valid;
	logic dst_ready = 1'b0;
	dst_t dst_data;

	// Requests waiting to be offered, and the track bytes still expected.
	src_t request_q[$];
	dst_t stream_q[$];

	// Predictor state: tick of the last channel event and bytes in this track.
	logic [TickW-1:0]  last_tick = '0;
	logic [CountW-1:0] bytes_in_track = '0;

	// Tick used to build the planned request list.
	logic [TickW-1:0] plan_tick = '0;

	int unsigned bad_bytes = 0;
	int unsigned requests_sent = 0;
	int unsigned src_gap = 0;
	int unsigned dst_stall = 0;
	int unsigned hold_left = 0;
	logic hold_done = 1'b0;
	logic quiet = 1'b0;
	dst_t want;

	midi_track_event_encoder_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Appends one expected byte and advances the track byte count.
	task automatic push_byte(input logic [7:0] value, input logic is_last);
		bytes_in_track = bytes_in_track + 1;
		stream_q.push_back('{out_byte: value, last: is_last, track_bytes: bytes_in_track});
	endtask

	// Works out the bytes that one accepted request produces.
	task automatic encode_request(input src_t req);
		logic [63:0] delta;
		int groups;
		if (req.action == ACT_EOT) begin
			push_byte(ZeroByte, 1'b0);
			push_byte(MetaMark, 1'b0);
			push_byte(MetaEot, 1'b0);
			push_byte(ZeroByte, 1'b1);
			last_tick = '0;
			bytes_in_track = '0;
		end else begin
			delta = {32'd0, req.tick - last_tick};
			groups = 1;
			while (groups < NumGroups && (delta >> (GroupW * groups)) != 0)
				groups++;
			// Most significant group first, continuation bit on all but the last.
			for (int i = groups - 1; i >= 0; i--)
				push_byte({i != 0, delta[GroupW * i +: GroupW]}, 1'b0);
			push_byte(req.status, 1'b0);
			push_byte(req.data_one, 1'b0);
			push_byte(req.data_two, 1'b1);
			last_tick = req.tick;
		end
	endtask

	task automatic queue_event(input logic [TickW-1:0] tick, input logic [7:0] status,
			input logic [7:0] pitch, input logic [7:0] velocity);
		request_q.push_back('{action: ACT_EVENT, tick: tick, status: status,
			data_one: pitch, data_two: velocity});
		plan_tick = tick;
	endtask

	task automatic queue_delta(input logic [TickW-1:0] delta, input logic [7:0] status,
			input logic [7:0] pitch, input logic [7:0] velocity);
		queue_event(plan_tick + delta, status, pitch, velocity);
	endtask

	// End of track; the other fields carry whatever junk is given.
	task automatic queue_eot(input logic [TickW-1:0] junk);
		request_q.push_back('{action: ACT_EOT, tick: junk, status: junk[7:0],
			data_one: junk[15:8], data_two: junk[23:16]});
		plan_tick = '0;
	endtask

	task automatic note_failure(input string msg);
		if (bad_bytes < 10)
			$display("%0t: %s", $realtime, msg);
		bad_bytes++;
	endtask

	// Sender: offers queued requests, holding each until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_data <= '0;
			src_gap <= 0;
		end else begin
			if (src_valid && src_ready) begin
				encode_request(src_data);
				requests_sent <= requests_sent + 1;
			end
			if (src_valid && !src_ready) begin
				src_valid <= 1'b1;
			end else if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				src_valid <= 1'b0;
			end else if (request_q.size() != 0) begin
				src_valid <= 1'b1;
				src_data <= request_q.pop_front();
				src_gap <= (quiet || $urandom_range(0, 4) != 0) ? 0 : $urandom_range(1, 14);
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// One long output stall once traffic is under way.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && requests_sent >= HoldAfter) begin
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end
	end

	// Receiver: ready with random stall bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_ready <= 1'b0;
			dst_stall <= 0;
		end else if (hold_left != 0) begin
			dst_ready <= 1'b0;
		end else if (dst_stall != 0) begin
			dst_stall <= dst_stall - 1;
			dst_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 6) == 0) begin
			dst_stall <= $urandom_range(0, 13);
			dst_ready <= 1'b0;
		end else begin
			dst_ready <= 1'b1;
		end
	end

	// Checker: every accepted byte against the oldest expected byte.
	always @(posedge clk) begin
		if (arst_n && dst_valid && dst_ready) begin
			if (stream_q.size() == 0) begin
				note_failure($sformatf("unexpected byte %02h last %b count %0d",
					dst_data.out_byte, dst_data.last, dst_data.track_bytes));
			end else begin
				want = stream_q.pop_front();
				if (dst_data.out_byte !== want.out_byte || dst_data.last !== want.last ||
						dst_data.track_bytes !== want.track_bytes)
					note_failure($sformatf(
						"byte %02h/%02h last %b/%b count %0d/%0d (actual/expected)",
						dst_data.out_byte, want.out_byte, dst_data.last, want.last,
						dst_data.track_bytes, want.track_bytes));
			end
		end
	end

	// Stimulus list, reset and end of run.
	initial begin
		int unsigned added;
		int unsigned track_len;
		int unsigned pick;
		int unsigned planned;
		logic [TickW-1:0] delta;

		// Delta lengths at every group boundary, then the wrap cases.
		queue_delta(32'd0, 8'h90, 8'h3c, 8'h40);
		queue_delta(32'd127, 8'h80, 8'h3c, 8'h00);
		queue_delta(32'd128, 8'h91, 8'h7f, 8'h7f);
		queue_delta(32'd16383, 8'h81, 8'h7f, 8'h00);
		queue_delta(32'd16384, 8'h9f, 8'h01, 8'h01);
		queue_delta(32'd2097151, 8'h8f, 8'h01, 8'h00);
		queue_delta(32'd2097152, 8'hb0, 8'h07, 8'h64);
		queue_delta(32'd268435455, 8'hc0, 8'h05, 8'h00);
		queue_delta(32'd268435456, 8'he0, 8'h00, 8'h40);
		queue_eot(32'hffff_ffff);
		// Largest possible delta, with all data bits set.
		queue_event(32'hffff_ffff, 8'hff, 8'hff, 8'hff);
		// A decreasing tick wraps around.
		queue_event(32'd5, 8'h00, 8'h00, 8'h00);
		queue_event(32'd5, 8'h90, 8'h80, 8'h7f);
		queue_event(32'h8000_0000, 8'h90, 8'h55, 8'haa);
		queue_event(32'h7fff_ffff, 8'h80, 8'haa, 8'h55);
		queue_eot(32'h0);
		// An empty track right after another end of track.
		queue_eot(32'h1234_5678);
		queue_event(32'h1234_5678, 8'h00, 8'h00, 8'h00);
		queue_eot(32'hdead_beef);

		// Random tracks: mostly sorted events, some wild ticks, then end of track.
		added = 0;
		while (added < RandomItems) begin
			track_len = $urandom_range(1, 8);
			for (int i = 0; i < track_len; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					delta = $urandom_range(0, 127);
				else if (pick < 7)
					delta = $urandom_range(128, 16383);
				else if (pick < 8)
					delta = $urandom_range(16384, 268435455);
				else
					delta = $urandom;
				if (pick == 9)
					queue_event($urandom, 8'($urandom), 8'($urandom), 8'($urandom));
				else
					queue_delta(delta, 8'h80 | 8'($urandom_range(0, 127)),
						8'($urandom_range(0, 127)), 8'($urandom_range(0, 127)));
				added++;
			end
			queue_eot($urandom);
			added++;
		end
		planned = request_q.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// No idling in the last part of the run.
		while (request_q.size() > QuietTail)
			@(posedge clk);
		quiet <= 1'b1;

		while (requests_sent != planned || stream_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (bad_bytes == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Run limit, well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
